>>> design/cps_pkg.sv
// Shared types, widths, register codes and the symmetric clamp for the
// clamped PID step block. No dependencies.
`timescale 1ns / 1ps

package cps_pkg;

  localparam int DataW  = 16;  // measured, target, gains
  localparam int ErrW   = 17;  // target minus measured
  localparam int LimW   = 15;  // clamp bound
  localparam int AccW   = 26;  // wide signed sum of the three terms
  localparam int DriveW = 17;  // result width
  localparam int IdxW   = 2;   // configuration register index

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_LIMIT      = 2'd3
  } cfg_reg_t;

  // Gains (signed Q8.8) and the clamp bound, as seen by the datapath
  typedef struct packed {
    logic signed [DataW-1:0] prop_gain;
    logic signed [DataW-1:0] integ_gain;
    logic signed [DataW-1:0] deriv_gain;
    logic        [LimW-1:0]  limit;
  } gains_t;

  // Clamp a wide signed value to [-lim, +lim]; the result always fits 16 bits
  function automatic logic signed [DataW-1:0] clamp_sym(
    input logic signed [AccW-1:0] v,
    input logic        [LimW-1:0] lim
  );
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = $signed({{(AccW-LimW){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      return hi[DataW-1:0];
    end else if (v < lo) begin
      return lo[DataW-1:0];
    end else begin
      return v[DataW-1:0];
    end
  endfunction

endpackage

>>> design/cps_cfg.sv
// Configuration register file for the clamped PID step block.
// Depends on cps_pkg for the register codes and the gains_t struct.
`timescale 1ns / 1ps

module cps_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cps_pkg::IdxW-1:0]  cfg_index,
  input  logic [cps_pkg::DataW-1:0] cfg_data,
  output cps_pkg::gains_t           gains
);

  cps_pkg::gains_t regs;

  // Writes never stall
  assign cfg_ready = 1'b1;
  assign gains     = regs;

  // Decode the index and update one register per request
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid) begin
      unique case (cps_pkg::cfg_reg_t'(cfg_index))
        cps_pkg::REG_PROP_GAIN:  regs.prop_gain  <= $signed(cfg_data);
        cps_pkg::REG_INTEG_GAIN: regs.integ_gain <= $signed(cfg_data);
        cps_pkg::REG_DERIV_GAIN: regs.deriv_gain <= $signed(cfg_data);
        cps_pkg::REG_LIMIT:      regs.limit      <= cfg_data[cps_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/clamped_pid_step_top.sv
// Top level of the clamped PID step: input register, two compute stages
// and an output register. Depends on cps_pkg and cps_cfg.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata: measured, target
//  m_*       out        m_tvalid/m_tready  m_tdata: drive
//  cfg_*     in         cfg_valid/ready    cfg_index, cfg_data
//
// One request is taken per cycle unless a stall on m_tready holds it; a result
// appears on m_tvalid after the term stage register, then the output register.
// The integral and previous error update once per request, in the term stage.
// A stall on m_tready holds every full stage; empty stages still fill.
// rst (synchronous) clears the stage valids, the state and all gains.
`timescale 1ns / 1ps

module clamped_pid_step_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] measured, [31:16] target
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [16:0] drive, [23:17] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cps_pkg::gains_t gains;

  cps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  // Pipeline registers
  logic                             v0;
  logic signed [cps_pkg::DataW-1:0] meas0;
  logic signed [cps_pkg::DataW-1:0] tgt0;
  logic                             v1;
  logic signed [cps_pkg::DataW-1:0] meas1;
  logic signed [cps_pkg::DataW-1:0] p1;
  logic signed [cps_pkg::DataW-1:0] integ1;
  logic signed [cps_pkg::DataW-1:0] d1;
  logic                             v2;
  logic signed [cps_pkg::DriveW-1:0] drive2;

  // Controller state
  logic signed [cps_pkg::DataW-1:0] integral;
  logic signed [cps_pkg::ErrW-1:0]  prev_err;

  // Stage flow control
  logic rdy1, rdy2, move01, move12;

  assign rdy2     = !v2 || m_tready;
  assign move12   = v1 && rdy2;
  assign rdy1     = !v1 || move12;
  assign move01   = v0 && rdy1;
  assign s_tready = !v0 || move01;

  // Term stage: error, proportional product, integral and derivative
  logic signed [cps_pkg::ErrW-1:0] err;
  logic signed [32:0]              prod_p;
  logic signed [17:0]              integ_sum;
  logic signed [17:0]              diff;
  logic signed [cps_pkg::DataW-1:0] p_next;
  logic signed [cps_pkg::DataW-1:0] integral_next;
  logic signed [cps_pkg::DataW-1:0] d_next;

  always_comb begin
    err       = $signed({tgt0[15], tgt0}) - $signed({meas0[15], meas0});
    prod_p    = err * gains.prop_gain;
    p_next    = cps_pkg::clamp_sym({prod_p[32], prod_p[32:8]}, gains.limit);
    integ_sum = $signed({{2{integral[15]}}, integral}) + $signed({err[16], err});
    integral_next = cps_pkg::clamp_sym({{8{integ_sum[17]}}, integ_sum}, gains.limit);
    diff      = $signed({err[16], err}) - $signed({prev_err[16], prev_err});
    d_next    = cps_pkg::clamp_sym({{8{diff[17]}}, diff}, gains.limit);
  end

  // Correction stage: integral and derivative products, sum, clamp, drive
  logic signed [31:0]               prod_i;
  logic signed [31:0]               prod_d;
  logic signed [cps_pkg::AccW-1:0]  corr_sum;
  logic signed [cps_pkg::DataW-1:0] corr;
  logic signed [cps_pkg::DriveW-1:0] drive_next;

  always_comb begin
    prod_i   = integ1 * gains.integ_gain;
    prod_d   = d1 * gains.deriv_gain;
    corr_sum = $signed({{10{p1[15]}}, p1})
             + $signed({{2{prod_i[31]}}, prod_i[31:8]})
             + $signed({{2{prod_d[31]}}, prod_d[31:8]});
    corr       = cps_pkg::clamp_sym(corr_sum, gains.limit);
    drive_next = $signed({meas1[15], meas1}) + $signed({corr[15], corr});
  end

  // Stage valids and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      integral <= '0;
      prev_err <= '0;
    end else begin
      if (s_tready) begin
        v0 <= s_tvalid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (move01) begin
        integral <= integral_next;
        prev_err <= err;
      end
    end
  end

  // Payload registers advance with their stage
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      meas0 <= $signed(s_tdata[15:0]);
      tgt0  <= $signed(s_tdata[31:16]);
    end
    if (move01) begin
      meas1  <= meas0;
      p1     <= p_next;
      integ1 <= integral_next;
      d1     <= d_next;
    end
    if (move12) begin
      drive2 <= drive_next;
    end
  end

  assign m_tvalid = v2;
  assign m_tdata  = {7'd0, drive2};

endmodule
